FILE: rtl/core/device_range_exclusion_bitmap_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the device range exclusion bitmap
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef DEVICE_RANGE_EXCLUSION_BITMAP_TOP_DEFINES_SVH
`define DEVICE_RANGE_EXCLUSION_BITMAP_TOP_DEFINES_SVH

// same-cycle implication
`define DRB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/drb_pkg.sv
// ----------------------------------------------------------------------------
// drb_pkg
// Opcodes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package drb_pkg;

    localparam logic [2:0] OP_MARK      = 3'd0;
    localparam logic [2:0] OP_UNMARK    = 3'd1;
    localparam logic [2:0] OP_UNMARK_ALL = 3'd2;
    localparam logic [2:0] OP_TEST      = 3'd3;
    localparam logic [2:0] OP_NEXT_RUN  = 3'd4;

    localparam int DEVNO_W = 16;

    // controller -> datapath
    typedef struct packed {
        logic req_load;   // capture request, clear results
        logic addr_clr;   // word address to zero
        logic clear_wr;   // write zero word, advance
        logic mem_rd;     // read word at address
        logic mem_wr;     // range update write, advance
        logic test_cap;   // capture test bit
        logic srch_step;  // evaluate one search word
        logic out_load;   // load output register
    } drb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       range_bad;
        logic       start_oob;
        logic       addr_top;
        logic       addr_at_last;
        logic       srch_again;  // run start found, recheck same word
        logic       srch_done;
        logic       out_busy;
    } drb_stat_t;

endpackage

FILE: rtl/core/drb_ctrl.sv
// ----------------------------------------------------------------------------
// drb_ctrl
// Request sequencer: clearing sweeps, range read-modify-write, test, search.
// ----------------------------------------------------------------------------
module drb_ctrl
    import drb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      req_valid,
    output logic      req_ready,
    input  drb_stat_t st,
    output drb_cmd_t  cmd
);

    typedef enum logic [10:0] {
        ST_INIT    = 11'b000_0000_0001,
        ST_IDLE    = 11'b000_0000_0010,
        ST_DISP    = 11'b000_0000_0100,
        ST_CLEAR   = 11'b000_0000_1000,
        ST_RNG_RD  = 11'b000_0001_0000,
        ST_RNG_WR  = 11'b000_0010_0000,
        ST_TST_RD  = 11'b000_0100_0000,
        ST_TST_CHK = 11'b000_1000_0000,
        ST_SRC_RD  = 11'b001_0000_0000,
        ST_SRC_CHK = 11'b010_0000_0000,
        ST_OUT     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.clear_wr = 1'b1;
                if (st.addr_top) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (req_valid) begin
                    cmd.req_load = 1'b1;
                    state_next   = ST_DISP;
                end
            end
            ST_DISP: begin
                priority if (st.op == OP_MARK || st.op == OP_UNMARK) begin
                    state_next = st.range_bad ? ST_OUT : ST_RNG_RD;
                end else if (st.op == OP_UNMARK_ALL) begin
                    cmd.addr_clr = 1'b1;
                    state_next   = ST_CLEAR;
                end else if (st.op == OP_TEST) begin
                    state_next = ST_TST_RD;
                end else if (st.op == OP_NEXT_RUN) begin
                    state_next = st.start_oob ? ST_OUT : ST_SRC_RD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (st.addr_top) state_next = ST_OUT;
            end
            ST_RNG_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_RNG_WR;
            end
            ST_RNG_WR: begin
                cmd.mem_wr = 1'b1;
                state_next = st.addr_at_last ? ST_OUT : ST_RNG_RD;
            end
            ST_TST_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_TST_CHK;
            end
            ST_TST_CHK: begin
                cmd.test_cap = 1'b1;
                state_next   = ST_OUT;
            end
            ST_SRC_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_SRC_CHK;
            end
            ST_SRC_CHK: begin
                cmd.srch_step = 1'b1;
                priority if (st.srch_done) state_next = ST_OUT;
                else if (st.srch_again)    state_next = ST_SRC_CHK;
                else                       state_next = ST_SRC_RD;
            end
            ST_OUT: begin
                if (!st.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/drb_dp.sv
// ----------------------------------------------------------------------------
// drb_dp
// Bitmap memory, request registers, word address, search and output register.
// ----------------------------------------------------------------------------
module drb_dp
    import drb_pkg::*;
#(
    parameter int NUM_DEVICES = 65536,
    parameter int WORD_BITS   = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  drb_cmd_t            cmd,
    output drb_stat_t           st,
    input  logic [2:0]          in_op,
    input  logic [DEVNO_W-1:0]  in_first,
    input  logic [DEVNO_W-1:0]  in_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [39:0]         out_data
);

    localparam int NWORDS = (NUM_DEVICES + WORD_BITS - 1) / WORD_BITS;
    localparam int BIDX   = $clog2(WORD_BITS);
    localparam int WIDX   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam logic [DEVNO_W:0]  NUM_L = (DEVNO_W + 1)'(NUM_DEVICES);
    localparam logic [WIDX-1:0]   TOP_W = WIDX'(NWORDS - 1);
    localparam logic [BIDX-1:0]   TOP_B = BIDX'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] mem [NWORDS];

    logic [2:0]         op_reg;
    logic [DEVNO_W-1:0] first_reg, last_reg;
    logic               range_bad_reg, start_oob_reg;
    logic [WIDX-1:0]    addr_reg;
    logic [WORD_BITS-1:0] rd_reg;
    logic               phase_reg;
    logic [BIDX:0]      lo_reg;
    logic               status_reg, listed_reg, found_reg;
    logic [DEVNO_W-1:0] rfirst_reg, rlast_reg;
    logic               out_valid_reg;
    logic [39:0]        out_data_reg;

    logic [DEVNO_W-1:0] last_eff;
    logic [WIDX-1:0]    first_w, last_w;
    logic [BIDX-1:0]    first_b, last_b, rng_lo, rng_hi;
    logic [WORD_BITS-1:0] rng_mask, wr_data, sdata, cand;
    logic               hit;
    logic [BIDX-1:0]    pos;
    logic [DEVNO_W-1:0] pos_devno;

    assign last_eff = (in_last == '0) ? in_first : in_last;
    assign first_w  = WIDX'(first_reg >> BIDX);
    assign last_w   = WIDX'(last_reg >> BIDX);
    assign first_b  = first_reg[BIDX-1:0];
    assign last_b   = last_reg[BIDX-1:0];

    // range mask for the current word
    assign rng_lo = (addr_reg == first_w) ? first_b : '0;
    assign rng_hi = (addr_reg == last_w) ? last_b : TOP_B;
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            rng_mask[i] = (BIDX'(i) >= rng_lo) && (BIDX'(i) <= rng_hi);
        end
    end
    assign wr_data = (op_reg == OP_MARK) ? (rd_reg | rng_mask) : (rd_reg & ~rng_mask);

    // search: lowest set bit (find phase) or lowest clear bit (run phase) at or above lo
    assign sdata = phase_reg ? ~rd_reg : rd_reg;
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            cand[i] = sdata[i] && ((BIDX + 1)'(i) >= lo_reg);
        end
    end
    assign hit = |cand;
    always_comb begin
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) pos = BIDX'(i);
        end
    end
    assign pos_devno = DEVNO_W'({addr_reg, pos});

    always_ff @(posedge aclk) begin
        if (cmd.clear_wr) mem[addr_reg] <= '0;
        else if (cmd.mem_wr) mem[addr_reg] <= wr_data;
        if (cmd.mem_rd) rd_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
        end else if (cmd.req_load) begin
            addr_reg <= WIDX'(in_first >> BIDX);
        end else if (cmd.addr_clr) begin
            addr_reg <= '0;
        end else if (cmd.clear_wr || cmd.mem_wr) begin
            addr_reg <= addr_reg + 1'b1;
        end else if (cmd.srch_step && !hit) begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            op_reg        <= in_op;
            first_reg     <= in_first;
            last_reg      <= last_eff;
            range_bad_reg <= (in_first > last_eff) || ({1'b0, last_eff} >= NUM_L);
            start_oob_reg <= ({1'b0, in_first} >= NUM_L);
            status_reg    <= ((in_op == OP_MARK) || (in_op == OP_UNMARK)) &&
                             ((in_first > last_eff) || ({1'b0, last_eff} >= NUM_L));
            listed_reg    <= 1'b0;
            found_reg     <= 1'b0;
            rfirst_reg    <= '0;
            rlast_reg     <= '0;
            phase_reg     <= 1'b0;
            lo_reg        <= {1'b0, in_first[BIDX-1:0]};
        end else if (cmd.test_cap) begin
            listed_reg <= !start_oob_reg && rd_reg[first_b];
        end else if (cmd.srch_step) begin
            if (hit) begin
                if (!phase_reg) begin
                    found_reg  <= 1'b1;
                    rfirst_reg <= pos_devno;
                    phase_reg  <= 1'b1;
                    lo_reg     <= (BIDX + 1)'(pos) + 1'b1;
                end else begin
                    rlast_reg <= pos_devno - 1'b1;
                end
            end else begin
                lo_reg <= '0;
                if (phase_reg && addr_reg == TOP_W) begin
                    rlast_reg <= DEVNO_W'({addr_reg, TOP_B});
                end
            end
        end
    end

    // output register, loads only when empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {5'b0, rlast_reg, rfirst_reg, found_reg, listed_reg, status_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign st.op           = op_reg;
    assign st.range_bad    = range_bad_reg;
    assign st.start_oob    = start_oob_reg;
    assign st.addr_top     = (addr_reg == TOP_W);
    assign st.addr_at_last = (addr_reg == last_w);
    assign st.srch_again   = hit && !phase_reg;
    assign st.srch_done    = (hit && phase_reg) || (!hit && addr_reg == TOP_W);
    assign st.out_busy     = out_valid_reg && !out_ready;

endmodule

FILE: rtl/core/device_range_exclusion_bitmap_top.sv
// ----------------------------------------------------------------------------
// device_range_exclusion_bitmap_top
// One exclusion bit per device number, with range, test and run-search ops.
// ----------------------------------------------------------------------------
// The bitmap lives in a single-port RAM of NUM_DEVICES/WORD_BITS words
// (WORD_BITS a power of two). After reset the block clears the RAM one word a
// cycle, with s_tready low. Each request gives one result item. Mark/unmark
// reads and then writes each word the range touches; a reversed or
// out-of-space range or an undefined op goes straight to the output register;
// unmark all is a clearing sweep; test reads one word; next run reads and
// examines each word scanned and examines the word where the run starts once
// more. The output register loads only once it is free. The single RAM port
// makes every word be read, then written or examined, one access a cycle.
// One request is in progress at a time; a new one is taken while the last
// result still waits in the output register.
// ----------------------------------------------------------------------------
`include "device_range_exclusion_bitmap_top_defines.svh"

module device_range_exclusion_bitmap_top
    import drb_pkg::*;
#(
    parameter int NUM_DEVICES = 65536,
    parameter int WORD_BITS   = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] first_devno, [31:16] last_devno
    input  logic [2:0]  s_tuser,   // [2:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] status, [1] is_listed, [2] run_found,
                                   // [18:3] run_first, [34:19] run_last, rest 0
);

    drb_cmd_t  cmd;
    drb_stat_t st;

    drb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .st        (st),
        .cmd       (cmd)
    );

    drb_dp #(
        .NUM_DEVICES (NUM_DEVICES),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .in_op     (s_tuser),
        .in_first  (s_tdata[15:0]),
        .in_last   (s_tdata[31:16]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // one request at a time
    `DRB_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    // a rejected range carries no test or search result
    `DRB_ASSERT_IMP(a_reject_clean, m_tvalid && m_tdata[0], m_tdata[2:1] == 2'b00, "bad reject")
    // single RAM port
    `DRB_ASSERT_IMP(a_one_port, cmd.mem_wr || cmd.clear_wr, !cmd.mem_rd, "RAM port conflict")
    // no result load over a waiting one
    `DRB_ASSERT_IMP(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready, "result overwritten")

endmodule

FILE: bench/drb_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drb_result_checker
// Watches both channels, keeps a shadow bitmap, predicts and compares results.
// ----------------------------------------------------------------------------
module drb_result_checker
    import drb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);
    localparam int NDEV = 65536;

    typedef struct packed {
        logic [15:0] run_last;
        logic [15:0] run_first;
        logic        run_found;
        logic        is_listed;
        logic        status;
    } drb_result_t;

    bit          shadow_map [NDEV];
    drb_result_t expected_results [$];

    function automatic drb_result_t apply_request(logic [2:0] op, int unsigned first,
                                                  int unsigned last);
        drb_result_t r;
        int unsigned n;
        r = '0;
        case (op)
            OP_MARK, OP_UNMARK: begin
                if (last == 0) last = first;
                if (first > last || last >= NDEV) r.status = 1'b1;
                else for (n = first; n <= last; n++) shadow_map[n] = (op == OP_MARK);
            end
            OP_UNMARK_ALL: foreach (shadow_map[i]) shadow_map[i] = 1'b0;
            OP_TEST: r.is_listed = (first < NDEV) ? shadow_map[first] : 1'b0;
            OP_NEXT_RUN: begin
                n = first;
                while (n < NDEV && !shadow_map[n]) n++;
                if (n < NDEV) begin
                    r.run_found = 1'b1;
                    r.run_first = n[15:0];
                    while (n + 1 < NDEV && shadow_map[n + 1]) n++;
                    r.run_last = n[15:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign pending_count = expected_results.size();

    initial begin
        fail_count = 0;
        foreach (shadow_map[i]) shadow_map[i] = 1'b0;
    end

    always @(posedge aclk) begin
        drb_result_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(s_tuser, s_tdata[15:0],
                                                         s_tdata[31:16]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[34:0];
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || m_tdata[39:35] !== 5'd0) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp st=%b li=%b fd=%b f=%h l=%h, got %h",
                                     want.status, want.is_listed, want.run_found,
                                     want.run_first, want.run_last, m_tdata);
                    end
                end
            end
        end
    end
endmodule

FILE: bench/device_range_exclusion_bitmap_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// device_range_exclusion_bitmap_top_tb
// Directed and random requests with random gaps and result stalls.
// ----------------------------------------------------------------------------
// Mostly small ranges and searches in a few clustered windows so runs touch,
// merge and split; a few wide and full-space ranges exercise long sweeps.
module device_range_exclusion_bitmap_top_tb;
    import drb_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    int          fail_count, pending_count;
    bit          stim_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    device_range_exclusion_bitmap_top dut (.*);

    drb_result_checker checker_i (.*);

    // send one item: random gap, then hold valid until accepted
    task automatic send_item(logic [2:0] op, logic [15:0] first, logic [15:0] last);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {last, first};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // addresses clustered in a window so operations interact
    function automatic logic [15:0] pick_devno(logic [15:0] base);
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'(16'hFFFF - $urandom_range(0, 80));
            default: return 16'(base + $urandom_range(0, 200));
        endcase
    endfunction

    // result side: random stall per item, some stall-free stretches
    initial begin
        int stall;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        logic [2:0]  op;
        logic [15:0] base, f, l;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: extremes and special cases
        send_item(OP_TEST, 16'd0, 16'd0);
        send_item(OP_NEXT_RUN, 16'd0, 16'd0);
        send_item(OP_MARK, 16'd0, 16'd0);            // single, zero last
        send_item(OP_MARK, 16'd63, 16'd64);          // straddles words
        send_item(OP_MARK, 16'hFFF0, 16'hFFFF);      // run to the top
        send_item(OP_TEST, 16'd0, 16'd0);
        send_item(OP_TEST, 16'd64, 16'hFFFF);
        send_item(OP_TEST, 16'hFFFF, 16'd0);
        send_item(OP_NEXT_RUN, 16'd1, 16'hFFFF);
        send_item(OP_NEXT_RUN, 16'd65, 16'd0);
        send_item(OP_NEXT_RUN, 16'hFFFF, 16'd0);
        send_item(OP_MARK, 16'd100, 16'd50);         // reversed range
        send_item(OP_UNMARK, 16'hFFFF, 16'd1);       // reversed range
        send_item(OP_UNMARK, 16'd64, 16'd0);
        send_item(OP_NEXT_RUN, 16'd60, 16'd0);
        send_item(3'd5, 16'hFFFF, 16'hFFFF);         // undefined ops
        send_item(3'd6, 16'h5555, 16'hAAAA);
        send_item(3'd7, 16'hAAAA, 16'h5555);
        send_item(OP_MARK, 16'd0, 16'hFFFF);         // whole space
        send_item(OP_NEXT_RUN, 16'd0, 16'd0);
        send_item(OP_UNMARK, 16'h8000, 16'h8000);
        send_item(OP_NEXT_RUN, 16'd0, 16'd0);
        send_item(OP_UNMARK_ALL, 16'hFFFF, 16'hFFFF);
        send_item(OP_NEXT_RUN, 16'd0, 16'd0);
        // random
        base = 16'($urandom);
        for (int i = 0; i < 560; i++) begin
            if ($urandom_range(0, 49) == 0) base = 16'($urandom);
            op = $urandom_range(0, 99) < 3 ? 3'($urandom_range(5, 7)) :
                 $urandom_range(0, 99) < 3 ? OP_UNMARK_ALL :
                 3'($urandom_range(0, 4));
            if (op == OP_UNMARK_ALL) op = ($urandom_range(0, 2) == 0) ? OP_TEST : op;
            f = pick_devno(base);
            case ($urandom_range(0, 9))
                0:       l = 16'd0;
                1:       l = 16'($urandom);
                2:       l = 16'(16'hFFFF - $urandom_range(0, 3));
                default: l = 16'(f + $urandom_range(0, 40));
            endcase
            send_item(op, f, l);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (2200) @(posedge aclk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #100ms;
        $display("status: fail");
        $finish;
    end
endmodule
